### rtl/slpe_pkg.sv
// shared types, constants and helpers for the serpentine led matrix pixel engine
package slpe_pkg;

  // matrix geometry
  localparam int ROWS    = 12;
  localparam int COLS    = 12;
  localparam int NPIX    = ROWS * COLS;
  localparam int DIM_MAX = (ROWS > COLS) ? ROWS : COLS;

  // coordinate width: holds the larger dimension itself and the 4-bit command fields
  localparam int CW = $clog2(DIM_MAX + 1);
  localparam int EW = (CW > 4) ? CW : 4;
  // strip address width and pixel count width
  localparam int AW = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int NW = $clog2(NPIX + 1);

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_ADD    = 2'd1,
    OP_INVERT = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_ALL       = 3'd0,
    REG_PIXEL     = 3'd1,
    REG_ROW       = 3'd2,
    REG_COL       = 3'd3,
    REG_ROW_RANGE = 3'd4,
    REG_COL_RANGE = 3'd5
  } region_t;

  // direction of the pixel walk
  typedef enum logic [1:0] {
    WALK_COLS,
    WALK_ROWS,
    WALK_ALL
  } walk_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    op_t        op;
    region_t    region;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] range_start;
    logic [3:0] range_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0] strip_index;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic [7:0] touched;
  } rsp_t;

  // write port of the frame memory
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    pixel_t        data;
  } mem_wr_t;

  // serpentine position: odd rows run backwards along the strip
  function automatic logic [AW-1:0] strip_pos(input logic [EW-1:0] r, input logic [EW-1:0] c);
    int pos;
    pos = int'(r) * COLS + (r[0] ? (COLS - 1 - int'(c)) : int'(c));
    return AW'(pos);
  endfunction

endpackage

### rtl/serpentine_led_matrix_pixel_engine.sv
// top level of the serpentine led matrix pixel engine: command sequencer and result register
// Each command walks N pixels, N being 144 for the whole matrix, 12 for a row or column
// and 1 for a pixel or a read, through the single read and write port pair of the frame
// memory, one pixel read-modify-write per cycle. A new command is taken only once the
// result of the last one has been loaded into the result register.
// Reset clears the control state and the per-pixel written flags, so the frame reads
// back black at once; no clearing pass is needed.
module serpentine_led_matrix_pixel_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  slpe_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output slpe_pkg::rsp_t  rsp
);
  import slpe_pkg::*;

  state_t         state;
  state_t         state_next;

  // command registers
  op_t            op_q;
  pixel_t         color_q;
  walk_t          walk_q;
  logic [EW-1:0]  r_pos;
  logic [EW-1:0]  c_pos;
  logic [NW-1:0]  cnt;
  logic [NW-1:0]  touched_q;
  logic           read_hit_q;
  logic [AW-1:0]  read_idx_q;

  // second stage of the read-modify-write
  logic           p1_valid;
  logic [AW-1:0]  p1_addr;

  // memory ports
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  pixel_t         rd_data;
  mem_wr_t        wr;

  logic           cmd_xfer;
  logic           rsp_load;

  // decoded command
  logic [EW-1:0]  row_e;
  logic [EW-1:0]  col_e;
  logic [EW-1:0]  s_lo;
  logic [EW-1:0]  s_hi;
  logic [EW-1:0]  e_cols;
  logic [EW-1:0]  e_rows;
  logic           row_ok;
  logic           col_ok;
  logic [EW-1:0]  init_r;
  logic [EW-1:0]  init_c;
  logic [NW-1:0]  init_cnt;
  walk_t          init_walk;

  slpe_frame_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // range ordering and clamping
  always_comb begin
    row_e  = EW'(cmd.row);
    col_e  = EW'(cmd.col);
    row_ok = row_e < EW'(ROWS);
    col_ok = col_e < EW'(COLS);
    if (cmd.range_start > cmd.range_end) begin
      s_lo = EW'(cmd.range_end);
      s_hi = EW'(cmd.range_start);
    end else begin
      s_lo = EW'(cmd.range_start);
      s_hi = EW'(cmd.range_end);
    end
    e_cols = (s_hi > EW'(COLS)) ? EW'(COLS) : s_hi;
    e_rows = (s_hi > EW'(ROWS)) ? EW'(ROWS) : s_hi;
  end

  // walk setup for the incoming command
  always_comb begin
    init_r    = '0;
    init_c    = '0;
    init_cnt  = '0;
    init_walk = WALK_COLS;
    if (cmd.op == OP_READ) begin
      init_r   = row_e;
      init_c   = col_e;
      init_cnt = (row_ok && col_ok) ? NW'(1) : '0;
    end else begin
      case (cmd.region)
        REG_ALL: begin
          init_walk = WALK_ALL;
          init_cnt  = NW'(NPIX);
        end
        REG_PIXEL: begin
          init_r   = row_e;
          init_c   = col_e;
          init_cnt = (row_ok && col_ok) ? NW'(1) : '0;
        end
        REG_ROW: begin
          init_r   = row_e;
          init_cnt = row_ok ? NW'(COLS) : '0;
        end
        REG_COL: begin
          init_walk = WALK_ROWS;
          init_c    = col_e;
          init_cnt  = col_ok ? NW'(ROWS) : '0;
        end
        REG_ROW_RANGE: begin
          init_r = row_e;
          init_c = s_lo;
          if (row_ok && (s_lo < e_cols)) begin
            init_cnt = NW'(e_cols - s_lo);
          end
        end
        REG_COL_RANGE: begin
          init_walk = WALK_ROWS;
          init_r    = s_lo;
          init_c    = col_e;
          if (col_ok && (s_lo < e_rows)) begin
            init_cnt = NW'(e_rows - s_lo);
          end
        end
        default: begin
          init_cnt = '0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    cmd_stall = 1'b1;
    rd_en     = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_stall = 1'b0;
      end
      S_WALK: begin
        rd_en = (cnt != '0);
      end
      S_DONE: begin
        rsp_load = !rsp_valid || !rsp_stall;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  assign cmd_xfer = cmd_valid && !cmd_stall;
  assign rd_addr  = strip_pos(r_pos, c_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture and pixel walk
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd_xfer) begin
      cnt <= init_cnt;
    end else if (rd_en) begin
      cnt <= cnt - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      op_q       <= cmd.op;
      color_q    <= '{red: cmd.red, green: cmd.green, blue: cmd.blue};
      walk_q     <= init_walk;
      r_pos      <= init_r;
      c_pos      <= init_c;
      touched_q  <= (cmd.op == OP_READ) ? '0 : init_cnt;
      read_hit_q <= (cmd.op == OP_READ) && row_ok && col_ok;
      read_idx_q <= strip_pos(row_e, col_e);
    end else if (rd_en) begin
      case (walk_q)
        WALK_COLS: begin
          c_pos <= c_pos + EW'(1);
        end
        WALK_ROWS: begin
          r_pos <= r_pos + EW'(1);
        end
        WALK_ALL: begin
          if (c_pos == EW'(COLS - 1)) begin
            c_pos <= '0;
            r_pos <= r_pos + EW'(1);
          end else begin
            c_pos <= c_pos + EW'(1);
          end
        end
        default: begin
          c_pos <= c_pos;
        end
      endcase
    end
  end

  // write-back stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= rd_en && (op_q != OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_addr <= rd_addr;
    end
  end

  // pixel modify: set, saturating add or invert
  always_comb begin
    logic [8:0] sum_r;
    logic [8:0] sum_g;
    logic [8:0] sum_b;
    sum_r   = {1'b0, rd_data.red}   + {1'b0, color_q.red};
    sum_g   = {1'b0, rd_data.green} + {1'b0, color_q.green};
    sum_b   = {1'b0, rd_data.blue}  + {1'b0, color_q.blue};
    wr.en   = p1_valid;
    wr.addr = p1_addr;
    case (op_q)
      OP_SET: begin
        wr.data = color_q;
      end
      OP_ADD: begin
        wr.data.red   = sum_r[8] ? 8'hFF : sum_r[7:0];
        wr.data.green = sum_g[8] ? 8'hFF : sum_g[7:0];
        wr.data.blue  = sum_b[8] ? 8'hFF : sum_b[7:0];
      end
      OP_INVERT: begin
        wr.data = ~rd_data;
      end
      default: begin
        wr.data = rd_data;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.touched <= 8'(touched_q);
      if (read_hit_q) begin
        rsp.strip_index <= 8'(read_idx_q);
        rsp.read_red    <= rd_data.red;
        rsp.read_green  <= rd_data.green;
        rsp.read_blue   <= rd_data.blue;
      end else begin
        rsp.strip_index <= '0;
        rsp.read_red    <= '0;
        rsp.read_green  <= '0;
        rsp.read_blue   <= '0;
      end
    end
  end

  // reads and write-backs within a walk never hit the same pixel
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr.en) |-> (rd_addr != wr.addr))
    else $error("read and write-back target the same pixel");

  // walk stays inside the frame
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (int'(rd_addr) < NPIX))
    else $error("frame address out of range");

  // write-back only follows a read of a modifying command
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> ($past(rd_en) && (op_q != OP_READ)))
    else $error("write-back without a preceding read");

  // a command that writes pixels reports no read colour
  a_write_no_read: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.touched != 8'd0)) |->
      ((rsp.read_red == 8'd0) && (rsp.read_green == 8'd0) && (rsp.read_blue == 8'd0)))
    else $error("read colour reported on a writing command");

endmodule

### rtl/slpe_frame_mem.sv
// frame store: one 24-bit pixel per strip position, reads back black until written
module slpe_frame_mem (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [slpe_pkg::AW-1:0]  rd_addr,
  output slpe_pkg::pixel_t         rd_data,
  input  slpe_pkg::mem_wr_t        wr
);
  import slpe_pkg::*;

  pixel_t            mem [NPIX];
  logic [NPIX-1:0]   written;

  // pixel array write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // per-entry written flags, cleared by reset so the frame starts black
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

### sim/serpentine_led_matrix_pixel_engine_tb.sv
// self-checking testbench for the serpentine led matrix pixel engine
`timescale 1ns / 1ps

module serpentine_led_matrix_pixel_engine_tb;
  import slpe_pkg::*;

  localparam int RANDOM_CMDS   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AT_RSP   = 60;
  localparam int TAIL_CYCLES   = 160;
  // region codes the block leaves unused
  localparam logic [2:0] REGION_SPARE_LO = 3'd6;
  localparam logic [2:0] REGION_SPARE_HI = 3'd7;

  typedef struct {
    cmd_t c;
    int   gap;
    bit   drain;
  } queued_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // predicted frame contents, indexed by strip position
  pixel_t      frame [NPIX];
  rsp_t        rsp_due [$];
  queued_cmd_t cmd_backlog [$];

  queued_cmd_t next_cmd;
  bit          have_next = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          cmds_sent = 0;
  int          rsps_seen = 0;
  int          reads_sent = 0;
  int          pixels_written = 0;
  int          cycles = 0;

  serpentine_led_matrix_pixel_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // odd rows run backwards along the strip
  function automatic int serp_index(int r, int c);
    return r * COLS + ((r % 2 == 1) ? (COLS - 1 - c) : c);
  endfunction

  function automatic void paint(int idx, cmd_t c);
    pixel_t     p;
    logic [8:0] sr, sg, sb;
    p = frame[idx];
    case (c.op)
      OP_SET: begin
        p = '{red: c.red, green: c.green, blue: c.blue};
      end
      OP_ADD: begin
        sr = {1'b0, p.red} + {1'b0, c.red};
        sg = {1'b0, p.green} + {1'b0, c.green};
        sb = {1'b0, p.blue} + {1'b0, c.blue};
        p.red   = sr[8] ? 8'hFF : sr[7:0];
        p.green = sg[8] ? 8'hFF : sg[7:0];
        p.blue  = sb[8] ? 8'hFF : sb[7:0];
      end
      default: begin
        p.red   = ~p.red;
        p.green = ~p.green;
        p.blue  = ~p.blue;
      end
    endcase
    frame[idx] = p;
  endfunction

  // apply one command to the predicted frame and return the result it should give
  function automatic rsp_t frame_apply(cmd_t c);
    rsp_t r;
    int   lo, hi, t, n, idx;
    r = '0;
    n = 0;
    if (c.op == OP_READ) begin
      reads_sent++;
      if (c.row < ROWS && c.col < COLS) begin
        idx = serp_index(c.row, c.col);
        r.strip_index = 8'(idx);
        r.read_red    = frame[idx].red;
        r.read_green  = frame[idx].green;
        r.read_blue   = frame[idx].blue;
      end
      return r;
    end
    lo = c.range_start;
    hi = c.range_end;
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    case (c.region)
      REG_ALL: begin
        for (int k = 0; k < NPIX; k++) begin
          paint(k, c);
          n++;
        end
      end
      REG_PIXEL: begin
        if (c.row < ROWS && c.col < COLS) begin
          paint(serp_index(c.row, c.col), c);
          n++;
        end
      end
      REG_ROW: begin
        if (c.row < ROWS)
          for (int k = 0; k < COLS; k++) begin
            paint(serp_index(c.row, k), c);
            n++;
          end
      end
      REG_COL: begin
        if (c.col < COLS)
          for (int k = 0; k < ROWS; k++) begin
            paint(serp_index(k, c.col), c);
            n++;
          end
      end
      REG_ROW_RANGE: begin
        if (c.row < ROWS) begin
          if (hi > COLS) hi = COLS;
          for (int k = lo; k < hi; k++) begin
            paint(serp_index(c.row, k), c);
            n++;
          end
        end
      end
      REG_COL_RANGE: begin
        // the column stays as given, only the range ends are swapped
        if (c.col < COLS) begin
          if (hi > ROWS) hi = ROWS;
          for (int k = lo; k < hi; k++) begin
            paint(serp_index(k, c.col), c);
            n++;
          end
        end
      end
      default: ;
    endcase
    pixels_written += n;
    r.touched = 8'(n);
    return r;
  endfunction

  function automatic cmd_t mk_cmd(op_t op, logic [2:0] region, int row, int col, int rs,
                                  int re, int r, int g, int b);
    cmd_t c;
    c.op          = op;
    c.region      = region_t'(region);
    c.row         = 4'(row);
    c.col         = 4'(col);
    c.range_start = 4'(rs);
    c.range_end   = 4'(re);
    c.red         = 8'(r);
    c.green       = 8'(g);
    c.blue        = 8'(b);
    return c;
  endfunction

  task automatic queue_cmd(cmd_t c, int gap, bit drain);
    queued_cmd_t q;
    q.c     = c;
    q.gap   = gap;
    q.drain = drain;
    cmd_backlog.push_back(q);
  endtask

  function automatic int pick_color();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // command driver: offers backlog items, holds payload while stalled
  always @(posedge clk) begin
    bit accepted;
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
      have_next = 1'b0;
      gap_left  = 0;
    end else begin
      accepted = cmd_valid && !cmd_stall;
      if (accepted) begin
        rsp_due.push_back(frame_apply(cmd));
        cmds_sent++;
      end
      if (!cmd_valid || accepted) begin
        // a draining item waits until every pending result has come back
        if (!have_next && cmd_backlog.size() > 0 &&
            (!cmd_backlog[0].drain || rsp_due.size() == 0)) begin
          next_cmd  = cmd_backlog.pop_front();
          have_next = 1'b1;
          gap_left  = next_cmd.gap;
        end
        if (have_next && gap_left == 0) begin
          cmd       <= next_cmd.c;
          cmd_valid <= 1'b1;
          have_next = 1'b0;
        end else begin
          cmd_valid <= 1'b0;
          if (have_next) gap_left--;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsps_seen++;
        if (rsp_due.size() == 0) begin
          $error("result transfer with no command outstanding");
          errors++;
        end else begin
          want = rsp_due.pop_front();
          check_field("strip_index", want.strip_index, rsp.strip_index);
          check_field("read_red", want.read_red, rsp.read_red);
          check_field("read_green", want.read_green, rsp.read_green);
          check_field("read_blue", want.read_blue, rsp.read_blue);
          check_field("touched", want.touched, rsp.touched);
        end
        // one long hold-off so the engine backs up onto its command side
        if (rsps_seen == HOLD_AT_RSP)
          hold_left = LONG_HOLD;
        else
          stall_left = ((rsps_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 12);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, rsp_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int op_sel, reg_sel, row, col, gap;
    op_t        op;
    logic [2:0] region;

    for (int k = 0; k < NPIX; k++) frame[k] = '0;

    // directed: reset state, extremes, swaps, clamps and out-of-range coordinates
    queue_cmd(mk_cmd(OP_READ, REG_ALL, 0, 0, 0, 0, 255, 255, 255), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_ALL, 0, 0, 0, 0, 255, 0, 128), 0, 1'b0);
    queue_cmd(mk_cmd(OP_READ, REG_PIXEL, 11, 11, 15, 15, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_ADD, REG_ALL, 0, 0, 0, 0, 128, 255, 127), 2, 1'b0);
    queue_cmd(mk_cmd(OP_INVERT, REG_PIXEL, 1, 0, 0, 0, 255, 255, 255), 0, 1'b0);
    queue_cmd(mk_cmd(OP_READ, REG_PIXEL, 1, 0, 0, 0, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_ROW, 11, 0, 0, 0, 1, 2, 3), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_COL, 0, 0, 0, 0, 0, 0, 0), 5, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_ROW_RANGE, 5, 0, 10, 3, 10, 20, 30), 0, 1'b0);
    queue_cmd(mk_cmd(OP_ADD, REG_COL_RANGE, 0, 7, 2, 15, 200, 100, 50), 0, 1'b0);
    queue_cmd(mk_cmd(OP_ADD, REG_ROW_RANGE, 3, 0, 12, 14, 1, 1, 1), 0, 1'b0);
    queue_cmd(mk_cmd(OP_INVERT, REG_COL_RANGE, 0, 4, 6, 6, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_PIXEL, 12, 3, 0, 0, 9, 9, 9), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_PIXEL, 3, 15, 0, 0, 9, 9, 9), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_ROW, 15, 0, 0, 0, 9, 9, 9), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REG_COL, 0, 12, 0, 0, 9, 9, 9), 0, 1'b0);
    queue_cmd(mk_cmd(OP_SET, REGION_SPARE_LO, 4, 4, 0, 15, 9, 9, 9), 0, 1'b0);
    queue_cmd(mk_cmd(OP_INVERT, REGION_SPARE_HI, 15, 15, 15, 15, 255, 255, 255), 0, 1'b0);
    queue_cmd(mk_cmd(OP_READ, REG_PIXEL, 15, 3, 0, 0, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_READ, REGION_SPARE_HI, 11, 0, 0, 0, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_READ, REG_COL, 0, 11, 0, 0, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_INVERT, REG_ALL, 0, 0, 0, 0, 0, 0, 0), 0, 1'b0);
    queue_cmd(mk_cmd(OP_ADD, REG_COL_RANGE, 0, 11, 15, 0, 17, 0, 255), 0, 1'b0);
    queue_cmd(mk_cmd(OP_READ, REG_PIXEL, 6, 11, 0, 0, 0, 0, 0), 0, 1'b0);

    // random: mostly valid coordinates, reads mixed in to observe the frame
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      op_sel  = $urandom_range(0, 99);
      reg_sel = $urandom_range(0, 99);
      if (op_sel < 30)      op = OP_READ;
      else if (op_sel < 55) op = OP_SET;
      else if (op_sel < 80) op = OP_ADD;
      else                  op = OP_INVERT;
      if (reg_sel < 10)      region = REG_ALL;
      else if (reg_sel < 30) region = REG_PIXEL;
      else if (reg_sel < 45) region = REG_ROW;
      else if (reg_sel < 60) region = REG_COL;
      else if (reg_sel < 77) region = REG_ROW_RANGE;
      else if (reg_sel < 94) region = REG_COL_RANGE;
      else if (reg_sel < 97) region = REGION_SPARE_LO;
      else                   region = REGION_SPARE_HI;
      row = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
      col = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
      // every third stretch of forty commands goes back to back
      gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 12);
      queue_cmd(mk_cmd(op, region, row, col, $urandom_range(0, 15), $urandom_range(0, 15),
                       pick_color(), pick_color(), pick_color()),
                gap, (i == 0 || i == 200 || i == 330));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drain: all commands sent and every result back, then a quiet tail
    while (cmd_backlog.size() > 0 || have_next || cmd_valid || rsp_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d commands (%0d pixel reads) and checked %0d results", cmds_sent,
             reads_sent, rsps_seen);
    $display("%0d pixel writes predicted over %0d cycles", pixels_written, cycles);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
